// File: rtl/packed_yuv422_to_rgb_macros.svh
// Assertion macros shared by the packed 4:2:2 to RGB converter.
`ifndef PACKED_YUV422_TO_RGB_MACROS_SVH
`define PACKED_YUV422_TO_RGB_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PYR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PYR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pyr_pkg.sv
// Types, constants and helper functions of the packed 4:2:2 to RGB converter.
`default_nettype none

package pyr_pkg;

	typedef enum logic {
		ORDER_YUYV = 1'b0,
		ORDER_UYVY = 1'b1
	} byte_order_t;

	localparam int COEF_W = 18;
	localparam int CHROMA_W = 9;
	localparam int PROD_W = COEF_W + CHROMA_W;
	localparam int FRAC_BITS = 15;
	localparam int TERM_W = 11;

	localparam logic signed [CHROMA_W-1:0] CHROMA_BIAS = 9'sd128;
	localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd37221;
	localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd12975;
	localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd18949;
	localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd66883;

	typedef logic signed [CHROMA_W-1:0] chroma_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [TERM_W-1:0] term_t;

	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

	typedef struct packed {
		logic [7:0] y0;
		logic [7:0] y1;
		chroma_t cu;
		chroma_t cv;
	} yuv_t;

	typedef struct packed {
		logic [7:0] y0;
		logic [7:0] y1;
		term_t rt;
		term_t gt;
		term_t bt;
	} term_set_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	function automatic chroma_t center(input logic [7:0] c);
		return chroma_t'($signed({1'b0, c}) - CHROMA_BIAS);
	endfunction

	// Floor division by 2^15; products stay well inside the kept bits.
	function automatic term_t floor_shift(input prod_t p);
		return $signed(p[FRAC_BITS+TERM_W-1:FRAC_BITS]);
	endfunction

	function automatic logic [7:0] pix_sat(input logic [7:0] y, input term_t t,
			input logic neg);
		term_t yx;
		term_t s;
		yx = $signed({3'b000, y});
		s = neg ? term_t'(yx - t) : term_t'(yx + t);
		if (s < 0) begin
			return 8'd0;
		end else if (s > 11'sd255) begin
			return 8'd255;
		end else begin
			return s[7:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/pyr_in_if.sv
// Input channel carrying one packed 4:2:2 macropixel per item.
`default_nettype none

interface pyr_in_if;
	logic valid;
	logic ready;
	logic [7:0] byte0;
	logic [7:0] byte1;
	logic [7:0] byte2;
	logic [7:0] byte3;
	logic last_in;

	modport source(output valid, output byte0, output byte1, output byte2, output byte3,
		output last_in, input ready);
	modport sink(input valid, input byte0, input byte1, input byte2, input byte3,
		input last_in, output ready);
endinterface

`default_nettype wire

// File: rtl/pyr_out_if.sv
// Output channel carrying one pair of RGB888 pixels per item.
`default_nettype none

interface pyr_out_if;
	logic valid;
	logic ready;
	logic [7:0] red_first;
	logic [7:0] green_first;
	logic [7:0] blue_first;
	logic [7:0] red_second;
	logic [7:0] green_second;
	logic [7:0] blue_second;
	logic last_out;

	modport source(output valid, output red_first, output green_first, output blue_first,
		output red_second, output green_second, output blue_second, output last_out,
		input ready);
	modport sink(input valid, input red_first, input green_first, input blue_first,
		input red_second, input green_second, input blue_second, input last_out,
		output ready);
endinterface

`default_nettype wire

// File: rtl/pyr_unpack.sv
// First stage: byte order selection and chroma centering.
`default_nettype none

module pyr_unpack import pyr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  byte_order_t byte_order,
	pyr_in_if.sink      yuv,
	input  logic        ready_s2,
	output stage_ctl_t  ctl_s1,
	output yuv_t        data_s1
);

	logic ready_s1;
	yuv_t unpacked;

	assign ready_s1 = !ctl_s1.valid || ready_s2;
	assign yuv.ready = ready_s1;

	always_comb begin
		unique case (byte_order)
			ORDER_YUYV: begin
				unpacked.y0 = yuv.byte0;
				unpacked.cu = center(yuv.byte1);
				unpacked.y1 = yuv.byte2;
				unpacked.cv = center(yuv.byte3);
			end
			ORDER_UYVY: begin
				unpacked.cu = center(yuv.byte0);
				unpacked.y0 = yuv.byte1;
				unpacked.cv = center(yuv.byte2);
				unpacked.y1 = yuv.byte3;
			end
			default: begin
				unpacked = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (ready_s1) begin
			ctl_s1.valid <= yuv.valid;
			ctl_s1.last <= yuv.last_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && yuv.valid) begin
			data_s1 <= unpacked;
		end
	end

endmodule

`default_nettype wire

// File: rtl/pyr_chroma.sv
// Second and third stages: chroma products and their scaled color terms.
`default_nettype none

module pyr_chroma import pyr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  stage_ctl_t ctl_s1,
	input  yuv_t       data_s1,
	output logic       ready_s2,
	input  logic       ready_s4,
	output stage_ctl_t ctl_s3,
	output term_set_t  term_s3
);

	stage_ctl_t ctl_s2;
	logic ready_s3;
	logic [7:0] y0_s2;
	logic [7:0] y1_s2;
	prod_t prod_rv_s2;
	prod_t prod_gu_s2;
	prod_t prod_gv_s2;
	prod_t prod_bu_s2;
	prod_t g_sum;

	assign ready_s3 = !ctl_s3.valid || ready_s4;
	assign ready_s2 = !ctl_s2.valid || ready_s3;
	assign g_sum = prod_t'(prod_gu_s2 + prod_gv_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (ready_s2) begin
				ctl_s2 <= ctl_s1;
			end
			if (ready_s3) begin
				ctl_s3 <= ctl_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && ctl_s1.valid) begin
			y0_s2 <= data_s1.y0;
			y1_s2 <= data_s1.y1;
			prod_rv_s2 <= prod_t'(data_s1.cv * COEF_RV);
			prod_gu_s2 <= prod_t'(data_s1.cu * COEF_GU);
			prod_gv_s2 <= prod_t'(data_s1.cv * COEF_GV);
			prod_bu_s2 <= prod_t'(data_s1.cu * COEF_BU);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && ctl_s2.valid) begin
			term_s3.y0 <= y0_s2;
			term_s3.y1 <= y1_s2;
			term_s3.rt <= floor_shift(prod_rv_s2);
			term_s3.gt <= floor_shift(g_sum);
			term_s3.bt <= floor_shift(prod_bu_s2);
		end
	end

endmodule

`default_nettype wire

// File: rtl/pyr_pixel.sv
// Fourth stage: luma plus color terms, saturation and the output register.
`default_nettype none

module pyr_pixel import pyr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  stage_ctl_t ctl_s3,
	input  term_set_t  term_s3,
	output logic       ready_s4,
	pyr_out_if.source  rgb
);

	stage_ctl_t ctl_s4;
	rgb_t first_s4;
	rgb_t second_s4;

	assign ready_s4 = !ctl_s4.valid || rgb.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (ready_s4) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && ctl_s3.valid) begin
			first_s4.r <= pix_sat(term_s3.y0, term_s3.rt, 1'b0);
			first_s4.g <= pix_sat(term_s3.y0, term_s3.gt, 1'b1);
			first_s4.b <= pix_sat(term_s3.y0, term_s3.bt, 1'b0);
			second_s4.r <= pix_sat(term_s3.y1, term_s3.rt, 1'b0);
			second_s4.g <= pix_sat(term_s3.y1, term_s3.gt, 1'b1);
			second_s4.b <= pix_sat(term_s3.y1, term_s3.bt, 1'b0);
		end
	end

	assign rgb.valid = ctl_s4.valid;
	assign rgb.last_out = ctl_s4.last;
	assign rgb.red_first = first_s4.r;
	assign rgb.green_first = first_s4.g;
	assign rgb.blue_first = first_s4.b;
	assign rgb.red_second = second_s4.r;
	assign rgb.green_second = second_s4.g;
	assign rgb.blue_second = second_s4.b;

endmodule

`default_nettype wire

// File: rtl/packed_yuv422_to_rgb.sv
// Top level of the packed 4:2:2 macropixel to RGB888 pixel pair converter.
//
//  Channel   Dir  Content
//  yuv       in   byte0..byte3 macropixel, last_in
//  rgb       out  two RGB888 pixels, last_out
//  cfg       in   cfg_we, cfg_data: byte order register
//
// One item is taken in every cycle while rgb does not stall; from acceptance to
// the result on rgb it passes the registered stages for unpacking, the chroma
// multiplies, the scaled terms and the saturating add in the output register.
// Reset clears the byte order to Y0 U Y1 V and empties the pipeline.
// A stall on rgb holds each full stage with no empty stage after it; empty stages keep filling.
`default_nettype none
`include "packed_yuv422_to_rgb_macros.svh"

module packed_yuv422_to_rgb import pyr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_data,
	pyr_in_if.sink   yuv,
	pyr_out_if.source rgb
);

	byte_order_t byte_order_q;
	stage_ctl_t ctl_s1;
	stage_ctl_t ctl_s3;
	yuv_t data_s1;
	term_set_t term_s3;
	logic ready_s2;
	logic ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= ORDER_YUYV;
		end else if (cfg_we) begin
			byte_order_q <= byte_order_t'(cfg_data);
		end
	end

	pyr_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_order (byte_order_q),
		.yuv        (yuv),
		.ready_s2   (ready_s2),
		.ctl_s1     (ctl_s1),
		.data_s1    (data_s1)
	);

	pyr_chroma u_chroma (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.data_s1  (data_s1),
		.ready_s2 (ready_s2),
		.ready_s4 (ready_s4),
		.ctl_s3   (ctl_s3),
		.term_s3  (term_s3)
	);

	pyr_pixel u_pixel (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s3   (ctl_s3),
		.term_s3  (term_s3),
		.ready_s4 (ready_s4),
		.rgb      (rgb)
	);

	`PYR_ASSERT_IMP(a_empty_out_takes_input, !rgb.valid, yuv.ready,
		"input stalled with empty output stage")
	`PYR_ASSERT_NXT(a_flow_latency,
		(yuv.valid && yuv.ready) ##1 rgb.ready ##1 rgb.ready ##1 rgb.ready,
		rgb.valid, "item did not reach the output in four cycles")
	`PYR_ASSERT_NXT(a_last_flows,
		(yuv.valid && yuv.ready && yuv.last_in) ##1 rgb.ready ##1 rgb.ready ##1 rgb.ready,
		rgb.last_out, "end of frame flag lost")

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for packed_yuv422_to_rgb with directed and random macropixels.
module tb;
	import pyr_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 9;
	localparam int PIPE_LATENCY = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_BATCH = 320;

	localparam int CHROMA_OFFSET = 128;
	localparam int SCALE_BITS = 15;
	localparam int GAIN_R_V = 37221;
	localparam int GAIN_G_U = 12975;
	localparam int GAIN_G_V = 18949;
	localparam int GAIN_B_U = 66883;

	typedef struct {
		rgb_t first;
		rgb_t second;
		logic last;
	} pixel_pair_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;

	pyr_in_if yuv_ch();
	pyr_out_if rgb_ch();

	byte_order_t order_model = ORDER_YUYV;
	pixel_pair_t pending_pairs[$];
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned pairs_seen = 0;
	int unsigned cycle_count = 0;

	packed_yuv422_to_rgb i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.yuv(yuv_ch),
		.rgb(rgb_ch)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [7:0] saturate_channel(input int sum);
		if (sum < 0) begin
			return 8'd0;
		end else if (sum > 255) begin
			return 8'd255;
		end else begin
			return sum[7:0];
		end
	endfunction

	function automatic rgb_t shade_pixel(input int luma, input int cu, input int cv);
		int red_term;
		int green_term;
		int blue_term;
		rgb_t px;
		red_term = (cv * GAIN_R_V) >>> SCALE_BITS;
		green_term = (cu * GAIN_G_U + cv * GAIN_G_V) >>> SCALE_BITS;
		blue_term = (cu * GAIN_B_U) >>> SCALE_BITS;
		px.r = saturate_channel(luma + red_term);
		px.g = saturate_channel(luma - green_term);
		px.b = saturate_channel(luma + blue_term);
		return px;
	endfunction

	function automatic pixel_pair_t convert_macropixel(input byte_order_t ord,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3, input logic lst);
		int y0;
		int y1;
		int cu;
		int cv;
		pixel_pair_t pair;
		if (ord == ORDER_UYVY) begin
			cu = int'(b0) - CHROMA_OFFSET;
			y0 = int'(b1);
			cv = int'(b2) - CHROMA_OFFSET;
			y1 = int'(b3);
		end else begin
			y0 = int'(b0);
			cu = int'(b1) - CHROMA_OFFSET;
			y1 = int'(b2);
			cv = int'(b3) - CHROMA_OFFSET;
		end
		pair.first = shade_pixel(y0, cu, cv);
		pair.second = shade_pixel(y1, cu, cv);
		pair.last = lst;
		return pair;
	endfunction

	function automatic logic [7:0] corner_byte();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd127;
			3: return 8'd128;
			4: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	task automatic report_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%s", msg);
		end
	endtask

	task automatic compare_channel(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			report_failure($sformatf("pair %0d %s: expected %0d, got %0d",
				pairs_seen, name, want, got));
		end
	endtask

	task automatic check_pair();
		pixel_pair_t want;
		pairs_seen++;
		if (pending_pairs.size() == 0) begin
			report_failure($sformatf("pair %0d arrived with no macropixel outstanding",
				pairs_seen));
		end else begin
			want = pending_pairs.pop_front();
			compare_channel("red_first", want.first.r, rgb_ch.red_first);
			compare_channel("green_first", want.first.g, rgb_ch.green_first);
			compare_channel("blue_first", want.first.b, rgb_ch.blue_first);
			compare_channel("red_second", want.second.r, rgb_ch.red_second);
			compare_channel("green_second", want.second.g, rgb_ch.green_second);
			compare_channel("blue_second", want.second.b, rgb_ch.blue_second);
			compare_channel("last_out", {7'd0, want.last}, {7'd0, rgb_ch.last_out});
		end
	endtask

	// The handshake is sampled on the falling edge, where every signal is settled.
	initial begin
		rgb_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rgb_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			@(negedge clk);
			if (arst_n === 1'b1 && rgb_ch.valid === 1'b1 && rgb_ch.ready === 1'b1) begin
				check_pair();
			end
		end
	end

	task automatic send_macropixel(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic lst);
		while ($urandom_range(99) < src_idle_pct) begin
			yuv_ch.valid <= 1'b0;
			@(posedge clk);
		end
		yuv_ch.valid <= 1'b1;
		yuv_ch.byte0 <= b0;
		yuv_ch.byte1 <= b1;
		yuv_ch.byte2 <= b2;
		yuv_ch.byte3 <= b3;
		yuv_ch.last_in <= lst;
		do begin
			@(negedge clk);
		end while (yuv_ch.ready !== 1'b1);
		@(posedge clk);
		pending_pairs.push_back(convert_macropixel(order_model, b0, b1, b2, b3, lst));
	endtask

	task automatic send_components(input logic [7:0] y0, input logic [7:0] u,
			input logic [7:0] y1, input logic [7:0] v, input logic lst);
		if (order_model == ORDER_UYVY) begin
			send_macropixel(u, y0, v, y1, lst);
		end else begin
			send_macropixel(y0, u, y1, v, lst);
		end
	endtask

	task automatic wait_idle();
		yuv_ch.valid <= 1'b0;
		while (pending_pairs.size() != 0) begin
			@(posedge clk);
		end
		repeat (2 * PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic set_byte_order(input byte_order_t ord);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= ord;
		@(posedge clk);
		cfg_we <= 1'b0;
		order_model = ord;
	endtask

	// Black, white, neutral gray and the chroma corners that drive every channel
	// past both ends of its range.
	task automatic run_extreme_macropixels();
		send_components(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_components(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		send_components(8'd0, 8'd128, 8'd255, 8'd128, 1'b0);
		send_components(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
		send_components(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
		send_components(8'd128, 8'd0, 8'd128, 8'd0, 1'b0);
		send_components(8'd128, 8'd255, 8'd128, 8'd255, 1'b1);
		send_components(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
		send_components(8'd255, 8'd255, 8'd0, 8'd0, 1'b0);
		send_components(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
		send_components(8'd1, 8'd127, 8'd254, 8'd129, 1'b1);
	endtask

	task automatic test_reset_byte_order();
		run_extreme_macropixels();
	endtask

	task automatic test_uyvy_byte_order();
		set_byte_order(ORDER_UYVY);
		run_extreme_macropixels();
	endtask

	task automatic test_random_macropixels(input byte_order_t ord, input int count);
		logic [7:0] b[4];
		logic lst;
		set_byte_order(ord);
		repeat (count) begin
			if ($urandom_range(9) < 7) begin
				foreach (b[k]) b[k] = 8'($urandom_range(255));
			end else begin
				foreach (b[k]) b[k] = corner_byte();
			end
			lst = ($urandom_range(15) == 0);
			send_macropixel(b[0], b[1], b[2], b[3], lst);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= 1'b0;
		yuv_ch.valid <= 1'b0;
		yuv_ch.byte0 <= 8'd0;
		yuv_ch.byte1 <= 8'd0;
		yuv_ch.byte2 <= 8'd0;
		yuv_ch.byte3 <= 8'd0;
		yuv_ch.last_in <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 26;
		sink_idle_pct = 78;
		test_reset_byte_order();
		test_uyvy_byte_order();
		test_random_macropixels(ORDER_YUYV, RANDOM_BATCH);
		test_random_macropixels(ORDER_UYVY, RANDOM_BATCH);
		wait_idle();

		src_idle_pct = 78;
		sink_idle_pct = 26;
		test_random_macropixels(ORDER_YUYV, RANDOM_BATCH);
		test_random_macropixels(ORDER_UYVY, RANDOM_BATCH);
		wait_idle();

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_macropixels(ORDER_UYVY, RANDOM_BATCH);
		test_random_macropixels(ORDER_YUYV, RANDOM_BATCH);
		wait_idle();

		if (mismatch_count == 0 && pending_pairs.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
